/* sv/pqe_pkg.sv */
`default_nettype none
package pqe_pkg;

  localparam int GRID_DEPTH   = 256;
  localparam int NUM_CURVES   = 4;
  localparam int POLY_TERMS   = 6;
  localparam int NUM_CHAINS   = 3;
  localparam int HORNER_SLOTS = POLY_TERMS - 1;
  localparam int SEARCH_STEPS = $clog2(GRID_DEPTH - 1);
  localparam int IDX_W        = $clog2(GRID_DEPTH - 1);
  localparam int GADDR_W      = $clog2(GRID_DEPTH);
  localparam int COEFF_ROWS   = NUM_CURVES * (GRID_DEPTH - 1);
  localparam int CADDR_W      = $clog2(COEFF_ROWS);
  localparam int NPTS_W       = 9;
  localparam int Q_W          = 48;
  localparam int DX_W         = 33;
  localparam int IN_TDATA_W   = 80;
  localparam int IN_TUSER_W   = 4;
  localparam int OUT_TDATA_W  = 152;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic REG_GRID_POINTS = 1'b0;

  typedef enum logic [1:0] {
    OP_GRID_WR  = 2'd0,
    OP_COEFF_WR = 2'd1,
    OP_EVAL     = 2'd2
  } opcode_e;

  // item travelling through the interval search
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [1:0]       curve;
    logic [7:0]       slot;
    logic [2:0]       cidx;
    logic [31:0]      wval;
    logic [31:0]      pos;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] mid;
  } srch_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] iv;
    logic [31:0]      pos;
  } ev_t;

  // horner accumulators after an add step
  typedef struct packed {
    logic                                 vld;
    logic [IDX_W-1:0]                     iv;
    logic                                 sat;
    logic [DX_W-1:0]                      dx;
    logic [POLY_TERMS-1:0][31:0]          c;
    logic [NUM_CHAINS-1:0][Q_W-1:0]       acc;
  } mc_t;

  // partial products of the magnitudes
  typedef struct packed {
    logic                                 vld;
    logic [IDX_W-1:0]                     iv;
    logic                                 sat;
    logic [DX_W-1:0]                      dx;
    logic [POLY_TERMS-1:0][31:0]          c;
    logic [NUM_CHAINS-1:0][Q_W-1:0]       acc;
    logic [NUM_CHAINS-1:0]                neg;
    logic [NUM_CHAINS-1:0][63:0]          plo;
    logic [NUM_CHAINS-1:0][47:0]          pmid;
  } ma_t;

  // rounded, clipped products
  typedef struct packed {
    logic                                 vld;
    logic [IDX_W-1:0]                     iv;
    logic                                 sat;
    logic [DX_W-1:0]                      dx;
    logic [POLY_TERMS-1:0][31:0]          c;
    logic [NUM_CHAINS-1:0][Q_W-1:0]       acc;
    logic [NUM_CHAINS-1:0][Q_W-1:0]       prod;
    logic [NUM_CHAINS-1:0]                psat;
  } mb_t;

  // scaled coefficient: value, first and second derivative chains
  function automatic logic [Q_W-1:0] kval(input int ch, input int idx, input logic [31:0] cv);
    logic [Q_W-1:0] ext;
    int             f;
    ext = {{(Q_W-32){cv[31]}}, cv};
    f   = 0;
    case (ch)
      0: f = 1;
      1: f = POLY_TERMS - 1 - idx;
      default: begin
        case (idx)
          0: f = 20;
          1: f = 12;
          2: f = 6;
          3: f = 2;
          default: f = 0;
        endcase
      end
    endcase
    return ext * Q_W'(f);
  endfunction

endpackage
`default_nettype wire

/* sv/piecewise_quintic_evaluator_unit.sv */
`default_nettype none
// Piecewise quintic evaluator: grid writes, coefficient writes and evaluations all enter on
// one stream and travel the same pipeline, one item per cycle, so a write takes effect for
// every later item and never for an earlier one. An evaluation passes nine search stages,
// one difference stage, one load stage and three stages for each of the five Horner
// steps before its result appears; writes produce nothing. The interval search
// is a binary search unrolled into stages, each with its own copy of the grid that the
// grid write updates as it passes; the coefficients sit in six banks read together once
// the interval is known. Arithmetic is Q16.16, every Horner step rounds half away from
// zero and clips to 48 bits, and tuser on the result flags any clipping. The whole
// pipeline holds while a result waits, so nothing is lost or repeated. grid_points_used
// sits at byte address 0 and should only be changed while the block is empty.
module piecewise_quintic_evaluator_unit
  import pqe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // slot_index, coeff_index, write_value, position, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode, curve_select
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // poly_value, first_deriv, second_deriv, interval_found
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // saturated
  output logic [0:0]                  m_axis_tuser_o,
  input  wire logic                   psel_i,
  input  wire logic                   penable_i,
  input  wire logic                   pwrite_i,
  input  wire logic [2:0]             paddr_i,
  input  wire logic [31:0]            pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  localparam int S = SEARCH_STEPS;
  localparam int H = HORNER_SLOTS;

  logic              adv;
  logic [NPTS_W-1:0] gpu_q;
  logic [NPTS_W-1:0] n_clamp;
  logic [IDX_W-1:0]  hi0;

  srch_t             srch_q [S+1];
  logic [IDX_W-1:0]  lo_r   [S+1];
  logic [IDX_W-1:0]  hi_r   [S+1];
  logic [IDX_W-1:0]  mid_n  [S+1];
  logic [31:0]       gd_q   [S+2];

  ev_t               ev_q;
  logic [31:0]       c9_q   [POLY_TERMS];

  logic                c_we;
  logic [CADDR_W-1:0]  c_wa;
  logic [CADDR_W-1:0]  c_ra;

  mc_t mc_q [H+1];
  mc_t mc_d [H+1];
  ma_t ma_q [H+1];
  ma_t ma_d [H+1];
  mb_t mb_q [H+1];
  mb_t mb_d [H+1];

  // whole pipeline moves together; the last stage is the output register
  assign adv             = !mc_q[H].vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // configuration register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_GRID_POINTS) ? 32'(gpu_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpu_q <= NPTS_W'(GRID_DEPTH);
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_GRID_POINTS)) begin
      gpu_q <= pwdata_i[NPTS_W-1:0];
    end
  end

  // out-of-range counts act as the nearest legal one
  always_comb begin
    n_clamp = gpu_q;
    if (gpu_q < NPTS_W'(2)) n_clamp = NPTS_W'(2);
    else if (int'(gpu_q) > GRID_DEPTH) n_clamp = NPTS_W'(GRID_DEPTH);
  end
  assign hi0 = IDX_W'(n_clamp - NPTS_W'(2));

  // search step resolution: each stage compares against the grid point read last stage
  always_comb begin
    logic [IDX_W:0] sum;
    for (int j = 0; j <= S; j++) begin
      lo_r[j] = srch_q[j].lo;
      hi_r[j] = srch_q[j].hi;
      if (j > 0 && srch_q[j].lo < srch_q[j].hi) begin
        if ($signed(gd_q[j]) <= $signed(srch_q[j].pos)) lo_r[j] = srch_q[j].mid;
        else hi_r[j] = srch_q[j].mid - IDX_W'(1);
      end
      sum      = {1'b0, lo_r[j]} + {1'b0, hi_r[j]} + (IDX_W+1)'(1);
      mid_n[j] = sum[IDX_W:1];
    end
  end

  // search pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= S; j++) srch_q[j].vld <= 1'b0;
      ev_q.vld <= 1'b0;
    end else if (adv) begin
      srch_q[0].vld   <= s_axis_tvalid_i;
      srch_q[0].op    <= s_axis_tuser_i[1:0];
      srch_q[0].curve <= s_axis_tuser_i[3:2];
      srch_q[0].slot  <= s_axis_tdata_i[7:0];
      srch_q[0].cidx  <= s_axis_tdata_i[10:8];
      srch_q[0].wval  <= s_axis_tdata_i[42:11];
      srch_q[0].pos   <= s_axis_tdata_i[74:43];
      srch_q[0].lo    <= '0;
      srch_q[0].hi    <= hi0;
      srch_q[0].mid   <= '0;
      for (int j = 0; j < S; j++) begin
        srch_q[j+1].vld   <= srch_q[j].vld;
        srch_q[j+1].op    <= srch_q[j].op;
        srch_q[j+1].curve <= srch_q[j].curve;
        srch_q[j+1].slot  <= srch_q[j].slot;
        srch_q[j+1].cidx  <= srch_q[j].cidx;
        srch_q[j+1].wval  <= srch_q[j].wval;
        srch_q[j+1].pos   <= srch_q[j].pos;
        srch_q[j+1].lo    <= lo_r[j];
        srch_q[j+1].hi    <= hi_r[j];
        srch_q[j+1].mid   <= mid_n[j];
      end
      ev_q.vld <= srch_q[S].vld && (srch_q[S].op == OP_EVAL)
                  && (int'(srch_q[S].curve) < NUM_CURVES);
      ev_q.iv  <= lo_r[S];
      ev_q.pos <= srch_q[S].pos;
    end
  end

  // one grid copy per search stage, written as a grid write passes that stage
  for (genvar j = 0; j <= S; j++) begin : g_grid
    logic [31:0]        mem [GRID_DEPTH];
    logic [GADDR_W-1:0] ra;
    if (j < S) begin : g_mid
      assign ra = GADDR_W'(mid_n[j]);
    end else begin : g_last
      assign ra = GADDR_W'(lo_r[j]);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (srch_q[j].vld && srch_q[j].op == OP_GRID_WR && int'(srch_q[j].slot) < GRID_DEPTH)
        begin
          mem[GADDR_W'(srch_q[j].slot)] <= srch_q[j].wval;
        end
        gd_q[j+1] <= mem[ra];
      end
    end
  end

  // coefficient banks, one per power, addressed by curve and interval
  assign c_we = srch_q[S].vld && (srch_q[S].op == OP_COEFF_WR)
                && (int'(srch_q[S].slot) < GRID_DEPTH - 1)
                && (int'(srch_q[S].cidx) < POLY_TERMS)
                && (int'(srch_q[S].curve) < NUM_CURVES);
  assign c_wa = CADDR_W'(srch_q[S].curve) * CADDR_W'(GRID_DEPTH - 1)
                + CADDR_W'(srch_q[S].slot);
  assign c_ra = CADDR_W'(srch_q[S].curve) * CADDR_W'(GRID_DEPTH - 1) + CADDR_W'(lo_r[S]);

  for (genvar b = 0; b < POLY_TERMS; b++) begin : g_coef
    logic [31:0] mem [COEFF_ROWS];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (c_we && srch_q[S].cidx == 3'(b)) mem[c_wa] <= srch_q[S].wval;
        c9_q[b] <= mem[c_ra];
      end
    end
  end

  // horner datapath: per step, multiply / round and clip / add and clip
  always_comb begin
    logic [Q_W-1:0]  a;
    logic [Q_W-1:0]  ua;
    logic [DX_W-1:0] ub33;
    logic [31:0]     ub;
    logic            huge;
    logic [Q_W:0]    mag;
    logic [Q_W-1:0]  limit;
    logic [Q_W-1:0]  magc;
    logic            satm;
    logic [Q_W-1:0]  k;
    logic [Q_W:0]    sum;
    logic            ovf;

    // load stage: dx and leading coefficients
    mc_d[0].vld = ev_q.vld;
    mc_d[0].iv  = ev_q.iv;
    mc_d[0].sat = 1'b0;
    mc_d[0].dx  = {ev_q.pos[31], ev_q.pos} - {gd_q[S+1][31], gd_q[S+1]};
    for (int i = 0; i < POLY_TERMS; i++) mc_d[0].c[i] = c9_q[i];
    for (int ch = 0; ch < NUM_CHAINS; ch++) mc_d[0].acc[ch] = kval(ch, 0, c9_q[0]);

    ma_d[0] = '0;
    mb_d[0] = '0;

    for (int t = 1; t <= H; t++) begin
      // magnitudes and partial products
      ma_d[t].vld  = mc_q[t-1].vld;
      ma_d[t].iv   = mc_q[t-1].iv;
      ma_d[t].sat  = mc_q[t-1].sat;
      ma_d[t].dx   = mc_q[t-1].dx;
      ma_d[t].c    = mc_q[t-1].c;
      ma_d[t].acc  = mc_q[t-1].acc;
      ub33 = mc_q[t-1].dx[DX_W-1] ? -mc_q[t-1].dx : mc_q[t-1].dx;
      ub   = ub33[31:0];
      for (int ch = 0; ch < NUM_CHAINS; ch++) begin
        a  = mc_q[t-1].acc[ch];
        ua = a[Q_W-1] ? -a : a;
        ma_d[t].neg[ch]  = a[Q_W-1] ^ mc_q[t-1].dx[DX_W-1];
        ma_d[t].plo[ch]  = 64'(ua[31:0]) * 64'(ub);
        ma_d[t].pmid[ch] = 48'(ua[Q_W-1:32]) * 48'(ub);
      end

      // round half away from zero, clip magnitude, restore sign
      mb_d[t].vld = ma_q[t].vld;
      mb_d[t].iv  = ma_q[t].iv;
      mb_d[t].sat = ma_q[t].sat;
      mb_d[t].dx  = ma_q[t].dx;
      mb_d[t].c   = ma_q[t].c;
      mb_d[t].acc = ma_q[t].acc;
      for (int ch = 0; ch < NUM_CHAINS; ch++) begin
        huge  = |ma_q[t].pmid[ch][47:32];
        mag   = {1'b0, ma_q[t].pmid[ch][31:0], 16'b0} + (Q_W+1)'(ma_q[t].plo[ch][63:16])
                + (Q_W+1)'(ma_q[t].plo[ch][15]);
        limit = ma_q[t].neg[ch] ? Q_MIN : Q_MAX;
        satm  = huge || (mag > {1'b0, limit});
        magc  = satm ? limit : mag[Q_W-1:0];
        mb_d[t].prod[ch] = ma_q[t].neg[ch] ? -magc : magc;
        mb_d[t].psat[ch] = satm;
      end

      // add scaled coefficient and clip; shorter chains hold once finished
      mc_d[t].vld = mb_q[t].vld;
      mc_d[t].iv  = mb_q[t].iv;
      mc_d[t].sat = mb_q[t].sat;
      mc_d[t].dx  = mb_q[t].dx;
      mc_d[t].c   = mb_q[t].c;
      mc_d[t].acc = mb_q[t].acc;
      for (int ch = 0; ch < NUM_CHAINS; ch++) begin
        k   = kval(ch, t, mb_q[t].c[t]);
        sum = {mb_q[t].prod[ch][Q_W-1], mb_q[t].prod[ch]} + {k[Q_W-1], k};
        ovf = sum[Q_W] ^ sum[Q_W-1];
        if (t < POLY_TERMS - ch) begin
          mc_d[t].acc[ch] = ovf ? (sum[Q_W] ? Q_MIN : Q_MAX) : sum[Q_W-1:0];
          if (ovf || mb_q[t].psat[ch]) mc_d[t].sat = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t <= H; t++) begin
        mc_q[t].vld <= 1'b0;
        ma_q[t].vld <= 1'b0;
        mb_q[t].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int t = 0; t <= H; t++) begin
        mc_q[t] <= mc_d[t];
        ma_q[t] <= ma_d[t];
        mb_q[t] <= mb_d[t];
      end
    end
  end

  assign m_axis_tvalid_o = mc_q[H].vld;
  assign m_axis_tdata_o  = {mc_q[H].iv, mc_q[H].acc[2], mc_q[H].acc[1], mc_q[H].acc[0]};
  assign m_axis_tuser_o  = mc_q[H].sat;

  // the unrolled search must have closed on a single interval
  a_search_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srch_q[S].vld && srch_q[S].op == OP_EVAL) |-> (lo_r[S] == hi_r[S]))
    else $error("search did not converge");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srch_q[1].vld && srch_q[1].op == OP_EVAL) |-> (srch_q[1].lo <= srch_q[1].hi))
    else $error("search bounds crossed");

  a_interval_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (int'(mc_q[H].iv) <= GRID_DEPTH - 2))
    else $error("interval beyond grid");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> srch_q[0].vld)
    else $error("accepted item lost at entry");

endmodule
`default_nettype wire

/* bench/pqe_result_checker.sv */
`timescale 1ns / 1ps
module pqe_result_checker
  import pqe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   s_axis_tvalid_i,
  input  wire logic                   s_axis_tready_i,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  wire logic                   m_axis_tvalid_i,
  input  wire logic                   m_axis_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  wire logic [0:0]             m_axis_tuser_i,
  input  wire logic                   psel_i,
  input  wire logic                   penable_i,
  input  wire logic                   pwrite_i,
  input  wire logic                   pready_i,
  input  wire logic [2:0]             paddr_i,
  input  wire logic [31:0]            pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [47:0] value;
    logic [47:0] first;
    logic [47:0] second;
    logic [7:0]  interval;
    logic        sat;
  } curve_point_t;

  localparam longint QHI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QLO = -64'sh0000_8000_0000_0000;

  logic signed [31:0] grid_mdl [GRID_DEPTH];
  logic signed [31:0] coeff_mdl [NUM_CURVES][GRID_DEPTH-1][POLY_TERMS];
  logic [8:0]         points_used;
  curve_point_t       expected_points [$];

  initial begin
    fail_count_o = 0;
    points_used  = 9'd256;
    foreach (grid_mdl[i]) grid_mdl[i] = '0;
    foreach (coeff_mdl[c, s, k]) coeff_mdl[c][s][k] = '0;
  end

  assign pending_o = expected_points.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic longint clip48(input longint v, inout bit sat);
    if (v > QHI) begin
      sat = 1'b1;
      return QHI;
    end
    if (v < QLO) begin
      sat = 1'b1;
      return QLO;
    end
    return v;
  endfunction

  // product rounded half away from zero, clipped to 48 bits
  function automatic longint mul_round(input longint a, input longint b, inout bit sat);
    logic signed [95:0] p;
    logic [95:0]        mag;
    logic [95:0]        lim;
    bit                 neg;
    p   = 96'(a) * 96'(b);
    neg = p[95];
    mag = neg ? 96'(-p) : 96'(p);
    mag = (mag + 96'd32768) >> 16;
    lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint horner_chain(input longint k [POLY_TERMS], input int count,
                                          input longint dx, inout bit sat);
    longint acc;
    acc = clip48(k[0], sat);
    for (int i = 1; i < count; i++) acc = clip48(mul_round(acc, dx, sat) + k[i], sat);
    return acc;
  endfunction

  function automatic curve_point_t evaluate(input logic [1:0] curve, input logic signed [31:0] pos);
    curve_point_t r;
    int           n, lo, hi, mid;
    longint       dx;
    longint       c [POLY_TERMS];
    longint       k [POLY_TERMS];
    bit           sat;
    sat = 1'b0;
    n   = points_used;
    if (n < 2) n = 2;
    if (n > GRID_DEPTH) n = GRID_DEPTH;
    lo = 0;
    hi = n - 2;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (grid_mdl[mid] <= pos) lo = mid;
      else hi = mid - 1;
    end
    dx = longint'(pos) - longint'(grid_mdl[lo]);
    foreach (c[j]) c[j] = longint'(coeff_mdl[curve][lo][j]);
    r.value = 48'(horner_chain(c, 6, dx, sat));
    k[0] = 5 * c[0]; k[1] = 4 * c[1]; k[2] = 3 * c[2]; k[3] = 2 * c[3]; k[4] = c[4]; k[5] = 0;
    r.first = 48'(horner_chain(k, 5, dx, sat));
    k[0] = 20 * c[0]; k[1] = 12 * c[1]; k[2] = 6 * c[2]; k[3] = 2 * c[3];
    r.second   = 48'(horner_chain(k, 4, dx, sat));
    r.interval = 8'(lo);
    r.sat      = sat;
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    logic [7:0]  slot;
    logic [2:0]  cidx;
    logic [31:0] wval;
    logic [31:0] pos;
    logic [1:0]  op;
    logic [1:0]  curve;
    curve_point_t got;
    curve_point_t want;
    if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 3'(4 * REG_GRID_POINTS))
      points_used = pwdata_i[8:0];
    if (s_axis_tvalid_i && s_axis_tready_i) begin
      slot  = s_axis_tdata_i[7:0];
      cidx  = s_axis_tdata_i[10:8];
      wval  = s_axis_tdata_i[42:11];
      pos   = s_axis_tdata_i[74:43];
      op    = s_axis_tuser_i[1:0];
      curve = s_axis_tuser_i[3:2];
      case (op)
        OP_GRID_WR: grid_mdl[slot] = wval;
        OP_COEFF_WR:
          if (slot < GRID_DEPTH - 1 && cidx < POLY_TERMS) coeff_mdl[curve][slot][cidx] = wval;
        OP_EVAL: expected_points.push_back(evaluate(curve, pos));
        default: ;
      endcase
    end
    if (m_axis_tvalid_i && m_axis_tready_i) begin
      got.value    = m_axis_tdata_i[47:0];
      got.first    = m_axis_tdata_i[95:48];
      got.second   = m_axis_tdata_i[143:96];
      got.interval = m_axis_tdata_i[151:144];
      got.sat      = m_axis_tuser_i[0];
      if (expected_points.size() == 0) begin
        report("unexpected result", 64'(got.value), 64'd0);
      end else begin
        want = expected_points.pop_front();
        if (got.value != want.value) report("poly_value", 64'(got.value), 64'(want.value));
        if (got.first != want.first) report("first_deriv", 64'(got.first), 64'(want.first));
        if (got.second != want.second)
          report("second_deriv", 64'(got.second), 64'(want.second));
        if (got.interval != want.interval)
          report("interval_found", 64'(got.interval), 64'(want.interval));
        if (got.sat != want.sat) report("saturated", 64'(got.sat), 64'(want.sat));
      end
    end
  end

endmodule

/* bench/tb_piecewise_quintic_evaluator_unit.sv */
`timescale 1ns / 1ps
module tb_piecewise_quintic_evaluator_unit;
  import pqe_pkg::*;

  // the opcode the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // slot, coeff index, write value, position, pad
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;   // opcode, curve
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // value, first, second, interval
  logic [0:0]             m_axis_tuser_o;   // saturated
  logic                   psel_i;
  logic                   penable_i;
  logic                   pwrite_i;
  logic [2:0]             paddr_i;
  logic [31:0]            pwdata_i;
  logic [31:0]            prdata_o;
  logic                   pready_o;
  int                     fail_count;
  int                     pending;

  // stimulus-side copy of the grid, only to aim positions near grid points
  logic signed [31:0] grid_shadow [GRID_DEPTH];
  bit                 src_idle;  // when set, the sender may leave gaps
  bit                 sink_idle; // when set, the receiver may stall

  piecewise_quintic_evaluator_unit dut (.*);

  pqe_result_checker checker_u (
    .clk_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .psel_i, .penable_i, .pwrite_i, .pready_i(pready_o), .paddr_i, .pwdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls at random while sink_idle is set
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b1;
    else if (sink_idle) m_axis_tready_i <= (gap_len() == 0);
    else m_axis_tready_i <= 1'b1;
  end

  task automatic send_item(input logic [1:0] op, input logic [1:0] curve, input logic [7:0] slot,
                           input logic [2:0] cidx, input logic [31:0] wval,
                           input logic [31:0] pos);
    int gap;
    gap = src_idle ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= {curve, op};
    s_axis_tdata_i  <= {5'd0, pos, wval, cidx, slot};
    if (op == OP_GRID_WR) grid_shadow[slot] = wval;
    // tready is steady at the falling edge, so the check is race free
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic write_points_used(input logic [31:0] value);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 3'(4 * REG_GRID_POINTS);
    pwdata_i  <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // let the pipeline empty, then some further cycles for trailing writes
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // coefficients: mostly modest, sometimes anywhere in 32 bits
  function automatic logic [31:0] rand_coeff();
    if ($urandom_range(0, 9) < 7) return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
    return $urandom();
  endfunction

  // positions: mostly near a grid point, some anywhere, some at the extremes
  function automatic logic [31:0] rand_position();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return grid_shadow[$urandom_range(0, GRID_DEPTH - 1)]
                       + 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
    if (r < 17) return $urandom();
    if (r == 17) return 32'h8000_0000;
    return 32'h7FFF_FFFF;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)
      send_item(OP_EVAL, 2'($urandom), 8'($urandom), 3'($urandom), $urandom(), rand_position());
    else if (r < 80)
      // interval 255 and coefficient numbers 6 and 7 are dropped by the block
      send_item(OP_COEFF_WR, 2'($urandom), 8'($urandom), 3'($urandom), rand_coeff(), $urandom());
    else if (r < 92)
      // grid rewrites mostly stay within the span of the sorted grid, and sometimes take any value
      send_item(OP_GRID_WR, 2'($urandom), 8'($urandom), 3'($urandom),
                ($urandom_range(0, 3) == 0) ? $urandom()
                : 32'(($signed(32'($urandom_range(0, 255))) - 128) * 32'sh10_0000
                      + $signed(32'($urandom_range(0, 32'hF_FFFF)))), $urandom());
    else
      send_item(OP_UNUSED, 2'($urandom), 8'($urandom), 3'($urandom), $urandom(), $urandom());
  endtask

  initial begin
    logic [31:0] point_settings [4];
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b1;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    src_idle        = 1'b0;
    sink_idle       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole grid (sorted) and every coefficient so no read hits an unwritten entry
    for (int i = 0; i < GRID_DEPTH; i++)
      send_item(OP_GRID_WR, 2'd0, 8'(i), 3'd0, 32'((i - 128) * 32'sh10_0000), 32'd0);
    for (int c = 0; c < NUM_CURVES; c++)
      for (int s = 0; s < GRID_DEPTH - 1; s++)
        for (int k = 0; k < POLY_TERMS; k++)
          send_item(OP_COEFF_WR, 2'(c), 8'(s), 3'(k), rand_coeff(), 32'd0);
    drain();

    // directed: field extremes, every operation, ignored writes and the unused opcode
    write_points_used(32'd256);
    send_item(OP_EVAL, 2'd0, 8'd0, 3'd0, 32'd0, 32'h8000_0000);     // below the grid
    send_item(OP_EVAL, 2'd3, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF); // above the grid
    send_item(OP_EVAL, 2'd1, 8'd0, 3'd0, 32'd0, grid_shadow[0]);    // exactly on a point
    send_item(OP_EVAL, 2'd2, 8'd0, 3'd0, 32'd0, grid_shadow[GRID_DEPTH - 1]);
    send_item(OP_COEFF_WR, 2'd3, 8'd254, 3'd0, 32'h7FFF_FFFF, 32'd0);  // huge, clips
    send_item(OP_COEFF_WR, 2'd3, 8'd254, 3'd5, 32'h8000_0000, 32'd0);
    send_item(OP_COEFF_WR, 2'd3, 8'd255, 3'd0, 32'h1234_5678, 32'd0);  // bad interval
    send_item(OP_COEFF_WR, 2'd3, 8'd10, 3'd6, 32'h1234_5678, 32'd0);   // bad coefficient
    send_item(OP_COEFF_WR, 2'd3, 8'd10, 3'd7, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_EVAL, 2'd3, 8'd0, 3'd0, 32'd0, 32'h7FFF_FFFF);
    send_item(OP_EVAL, 2'd3, 8'd0, 3'd0, 32'd0, grid_shadow[10] + 32'd1);
    send_item(OP_UNUSED, 2'd3, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_GRID_WR, 2'd0, 8'd255, 3'd0, 32'h7FFF_FFFF, 32'd0);
    send_item(OP_EVAL, 2'd0, 8'd0, 3'd0, 32'd0, 32'h7FFF_FFF0);
    send_item(OP_GRID_WR, 2'd0, 8'd255, 3'd0, 32'h0800_0000, 32'd0);
    drain();
    write_points_used(32'd2);                                       // single interval
    send_item(OP_EVAL, 2'd0, 8'd0, 3'd0, 32'd0, 32'h8000_0000);
    send_item(OP_EVAL, 2'd1, 8'd0, 3'd0, 32'd0, 32'h7FFF_FFFF);
    drain();
    write_points_used(32'd0);                                       // acts as two
    send_item(OP_EVAL, 2'd2, 8'd0, 3'd0, 32'd0, 32'h0001_0000);
    drain();
    write_points_used(32'd511);                                     // acts as the full grid
    send_item(OP_EVAL, 2'd3, 8'd0, 3'd0, 32'd0, 32'h7FFF_FFFF);
    send_item(OP_EVAL, 2'd0, 8'd0, 3'd0, 32'd0, grid_shadow[200]);
    drain();

    // random phases, each under its own grid size
    point_settings[0] = 32'd256;
    point_settings[1] = 32'($urandom_range(3, 255));
    point_settings[2] = 32'd2;
    point_settings[3] = $urandom();
    foreach (point_settings[p]) begin
      write_points_used(point_settings[p]);
      for (int i = 0; i < 100; i++) begin
        // stretches with and without idling on either side
        if (i % 25 == 0) begin
          src_idle  = $urandom_range(0, 3) != 0;
          sink_idle = $urandom_range(0, 3) != 0;
        end
        random_item();
      end
      drain();
    end

    sink_idle = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
